>>> src/fla_pkg.sv
// Package with types, codes and defaults for the free-list segment allocator.
package fla_pkg;

  localparam int FREE_SEGMENTS_DEF = 16;
  localparam int BUSY_BLOCKS_DEF   = 16;
  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;
  localparam logic [LEN_W-1:0] POOL_MAX = 17'd65536;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Action codes.
  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  // Configuration register indexes.
  localparam logic CFG_FIT_MODE  = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic [0:0]       action;
    logic [LEN_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } item_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [1:0]        status;
  } item_out_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ASCAN,
    S_ABUSY,
    S_ACOMMIT,
    S_BSCAN,
    S_RSCAN,
    S_RFREE,
    S_RCOMMIT,
    S_DONE
  } state_t;

endpackage

>>> src/free_list_segment_allocator.sv
// Top level of the free-list segment allocator: tables, scan sequencer and ports.
//
// Channel | Signals                              | Handshake
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | valid and ready
// in      | start busy in_item                   | start while not busy
// out     | done out_item                        | one-cycle strobe
//
// An allocate scans the free table and then the busy table; a release scans the
// busy table and then the free table twice: one shared compare unit visits one table
// entry a cycle. Writing pool_size starts a clearing pass over both tables;
// reset runs the same pass.
// Results are shown for one cycle with done and cannot be stalled.
module free_list_segment_allocator #(
  parameter int FREE_SEGMENTS = fla_pkg::FREE_SEGMENTS_DEF,
  parameter int BUSY_BLOCKS   = fla_pkg::BUSY_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [16:0]       cfg_data,
  input  logic              start,
  output logic              busy,
  input  fla_pkg::item_in_t in_item,
  output logic              done,
  output fla_pkg::item_out_t out_item
);
  import fla_pkg::*;

  localparam int FW = (FREE_SEGMENTS > 1) ? $clog2(FREE_SEGMENTS) : 1;
  localparam int BW = (BUSY_BLOCKS > 1) ? $clog2(BUSY_BLOCKS) : 1;
  localparam int NMAX = (FREE_SEGMENTS > BUSY_BLOCKS) ? FREE_SEGMENTS : BUSY_BLOCKS;
  localparam int CW = $clog2(NMAX + 1);

  // Tables.
  logic [ADDR_W-1:0] free_start [FREE_SEGMENTS];
  logic [LEN_W-1:0]  free_length [FREE_SEGMENTS];
  logic [FREE_SEGMENTS-1:0] free_used;
  logic [ADDR_W-1:0] busy_start [BUSY_BLOCKS];
  logic [LEN_W-1:0]  busy_length [BUSY_BLOCKS];
  logic [BUSY_BLOCKS-1:0] busy_used;

  logic fit_mode;
  logic [LEN_W-1:0] pool_size;

  state_t state, state_next;
  logic [CW-1:0] cnt;
  item_in_t req;

  // Scan results.
  logic pick_ok, slot_ok, left_ok, right_ok;
  logic [FW-1:0] pick, fslot, left, right;
  logic [BW-1:0] bslot, blk;
  logic [ADDR_W-1:0] pick_start;
  logic [LEN_W-1:0]  pick_len;
  logic [ADDR_W-1:0] bs;
  logic [LEN_W-1:0]  bl;

  logic [FW-1:0] fi;
  logic [BW-1:0] bi;
  logic last_f, last_b;

  assign fi = cnt[FW-1:0];
  assign bi = cnt[BW-1:0];
  assign last_f = (cnt == CW'(FREE_SEGMENTS - 1));
  assign last_b = (cnt == CW'(BUSY_BLOCKS - 1));

  // Shared unit: one entry compare per cycle.
  logic [ADDR_W-1:0] e_start;
  logic [LEN_W-1:0]  e_len;
  logic              e_used;
  logic [LEN_W:0]    e_end;
  logic              fits, better;
  logic [LEN_W:0]    b_end;

  assign e_start = free_start[fi];
  assign e_len   = free_length[fi];
  assign e_used  = free_used[fi];
  assign e_end   = {2'b0, e_start} + {1'b0, e_len};
  assign b_end   = {2'b0, bs} + {1'b0, bl};
  assign fits    = e_used && (e_len >= req.request_size);
  assign better  = !fit_mode ? (e_start < pick_start)
                 : ((e_len < pick_len) || (e_len == pick_len && e_start < pick_start));

  // An item offered in the same cycle as a register write goes first.
  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = (in_item.action == ACT_ALLOC) ? S_ASCAN : S_BSCAN;
        else if (cfg_valid && cfg_index == CFG_POOL_SIZE) state_next = S_INIT;
      end
      S_INIT:  if (cnt == CW'(NMAX - 1)) state_next = S_IDLE;
      S_ASCAN: begin
        if (req.request_size == '0) state_next = S_DONE;
        else if (last_f) state_next = S_ABUSY;
      end
      S_ABUSY: begin
        if (!pick_ok) state_next = S_DONE;
        else if (!busy_used[bi] || last_b) state_next = S_ACOMMIT;
      end
      S_ACOMMIT: state_next = S_DONE;
      S_BSCAN: begin
        if (busy_used[bi] && busy_start[bi] == req.block_address) state_next = S_RSCAN;
        else if (last_b) state_next = S_DONE;
      end
      S_RSCAN: if (last_f) state_next = S_RFREE;
      S_RFREE: begin
        if (left_ok || right_ok || !free_used[fi] || last_f) state_next = S_RCOMMIT;
      end
      S_RCOMMIT: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    done = (state == S_DONE);
  end

  // Sequencer registers and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
      fit_mode <= 1'b0;
      pool_size <= POOL_MAX;
      out_item <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          cnt <= '0;
          pick_ok <= 1'b0; slot_ok <= 1'b0; left_ok <= 1'b0;
          right_ok <= 1'b0;
          if (start) begin
            req <= in_item;
          end else if (cfg_valid) begin
            if (cfg_index == CFG_FIT_MODE) fit_mode <= cfg_data[0];
            else if (cfg_data == '0) pool_size <= 17'd1;
            else if (cfg_data > POOL_MAX) pool_size <= POOL_MAX;
            else pool_size <= cfg_data;
          end
        end
        S_INIT: cnt <= cnt + 1'b1;
        S_ASCAN: begin
          if (fits && (!pick_ok || better)) begin
            pick_ok <= 1'b1; pick <= fi; pick_start <= e_start; pick_len <= e_len;
          end
          cnt <= last_f ? '0 : cnt + 1'b1;
          if (req.request_size == '0) out_item <= '{'0, ST_NOFIT};
        end
        S_ABUSY: begin
          if (!pick_ok) out_item <= '{'0, ST_NOFIT};
          else if (!busy_used[bi]) begin
            slot_ok <= 1'b1; bslot <= bi;
          end else if (last_b) out_item <= '{'0, ST_FULL};
          cnt <= cnt + 1'b1;
        end
        S_ACOMMIT: if (slot_ok) out_item <= '{pick_start, ST_OK};
        S_BSCAN: begin
          if (busy_used[bi] && busy_start[bi] == req.block_address) begin
            blk <= bi; bs <= busy_start[bi]; bl <= busy_length[bi];
            cnt <= '0;
          end else begin
            if (last_b) out_item <= '{'0, ST_UNKNOWN};
            cnt <= cnt + 1'b1;
          end
        end
        S_RSCAN: begin
          if (e_used) begin
            if (e_end == {2'b0, bs}) begin
              left_ok <= 1'b1; left <= fi;
            end else if ({2'b0, e_start} == b_end) begin
              right_ok <= 1'b1; right <= fi;
            end
          end
          cnt <= last_f ? '0 : cnt + 1'b1;
        end
        S_RFREE: begin
          if (!left_ok && !right_ok) begin
            if (!free_used[fi]) begin
              slot_ok <= 1'b1; fslot <= fi;
            end
            cnt <= cnt + 1'b1;
          end
        end
        S_RCOMMIT: begin
          if (left_ok || right_ok || slot_ok) out_item <= '{'0, ST_OK};
          else out_item <= '{'0, ST_FULL};
        end
        default: ;
      endcase
    end
  end

  // Table updates.
  always_ff @(posedge clk) begin
    if (rst || state == S_INIT) begin
      if (cnt < CW'(FREE_SEGMENTS)) begin
        free_start[fi] <= '0;
        free_length[fi] <= (fi == '0) ? pool_size : '0;
        free_used[fi] <= (fi == '0);
      end
      if (cnt < CW'(BUSY_BLOCKS)) busy_used[bi] <= 1'b0;
    end else if (state == S_ACOMMIT && slot_ok) begin
      busy_used[bslot] <= 1'b1;
      busy_start[bslot] <= pick_start;
      busy_length[bslot] <= req.request_size;
      if (pick_len == req.request_size) begin
        free_used[pick] <= 1'b0;
        free_start[pick] <= '0;
        free_length[pick] <= '0;
      end else begin
        free_start[pick] <= pick_start + req.request_size[ADDR_W-1:0];
        free_length[pick] <= pick_len - req.request_size;
      end
    end else if (state == S_RCOMMIT && (left_ok || right_ok || slot_ok)) begin
      busy_used[blk] <= 1'b0;
      if (left_ok && right_ok) begin
        free_length[left] <= free_length[left] + bl + free_length[right];
        free_used[right] <= 1'b0;
        free_start[right] <= '0;
        free_length[right] <= '0;
      end else if (left_ok) begin
        free_length[left] <= free_length[left] + bl;
      end else if (right_ok) begin
        free_start[right] <= bs;
        free_length[right] <= free_length[right] + bl;
      end else begin
        free_used[fslot] <= 1'b1;
        free_start[fslot] <= bs;
        free_length[fslot] <= bl;
      end
    end
  end

endmodule

>>> src/fla_checker.sv
// Port checker for the free-list segment allocator, bound to the top level.
module fla_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_ready,
  input fla_pkg::item_out_t out_item
);
  import fla_pkg::*;

  // A result is never shown while idle.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // An accepted item makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept not followed by busy");

  // Each result is followed by idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after done");

  // A failed result carries address zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_item.status != ST_OK) |-> out_item.granted_address == '0)
    else $error("nonzero address on failure");

  // Register writes are taken only while no item is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst) cfg_ready |-> !busy)
    else $error("cfg_ready while busy");

endmodule

bind free_list_segment_allocator fla_checker u_fla_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .cfg_ready(cfg_ready), .out_item(out_item)
);
